@@ rtl/core/asrve_pkg.sv @@
// Shared types and constants of the attack-sustain-release volume envelope.
`default_nettype none
package asrve_pkg;

	// Envelope phase codes
	typedef enum logic [1:0] {
		PH_ATTACK  = 2'd0,
		PH_SUSTAIN = 2'd1,
		PH_RELEASE = 2'd2
	} env_phase_t;

	// Input action codes
	localparam logic [1:0] ACT_TICK        = 2'd0;
	localparam logic [1:0] ACT_FINAL_REL   = 2'd1;
	localparam logic [1:0] ACT_SAMPLE_END  = 2'd2;
	localparam logic [1:0] ACT_RESTART     = 2'd3;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_PEAK_VOLUME  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_TICKS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LOOP_DELAY   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE  = 3'd5;

	// Widths and limits
	localparam int unsigned LEVEL_W = 16;
	localparam int unsigned CNT_W   = 32;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 16'd40960;
	localparam logic [LEVEL_W-1:0] PEAK_RESET  = 16'd28672;
	localparam logic [CNT_W-1:0]   CNT_MAX     = 32'hFFFF_FFFF;
	localparam int unsigned DIV_STEPS_W = 4;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE = 3'd0,
		ST_PREP = 3'd1,
		ST_MUL  = 3'd2,
		ST_DIV  = 3'd3,
		ST_OUT  = 3'd4
	} ctrl_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic accept;
		logic prep;
		logic mul;
		logic div_step;
		logic out_load;
	} ctrl_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic need_div;
		logic div_last;
	} dp_status_t;

	// Clamp a Q4.12 value to 10.0
	function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] v);
		clamp_level = (v > LEVEL_MAX) ? LEVEL_MAX : v;
	endfunction

	// Counter increment that sticks at all ones
	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == CNT_MAX) ? v : v + 32'd1;
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/asrve_ifs.sv @@
// Channel interfaces: input items, result items and configuration writes.
`default_nettype none
interface asrve_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic signed [31:0] time_left;

	modport source (output valid, action, time_left, input ready);
	modport sink   (input valid, action, time_left, output ready);
endinterface

interface asrve_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] level;
	logic        finished;
	logic        retrigger;
	logic [1:0]  phase;

	modport source (output valid, level, finished, retrigger, phase, input ready);
	modport sink   (input valid, level, finished, retrigger, phase, output ready);
endinterface

interface asrve_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/asrve_ctrl.sv @@
// Controller state machine sequencing one envelope step.
`default_nettype none
module asrve_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	input  wire asrve_pkg::dp_status_t  status,
	output asrve_pkg::ctrl_cmd_t        cmd
);

	asrve_pkg::ctrl_state_t state_q, state_d;
	logic out_valid_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= asrve_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Result valid flag: set on load, cleared on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			asrve_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = asrve_pkg::ST_PREP;
				end
			end
			asrve_pkg::ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = asrve_pkg::ST_MUL;
			end
			asrve_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = status.need_div ? asrve_pkg::ST_DIV : asrve_pkg::ST_OUT;
			end
			asrve_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = asrve_pkg::ST_OUT;
				end
			end
			asrve_pkg::ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = asrve_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = asrve_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/core/asrve_datapath.sv @@
// Envelope datapath: configuration, state update, multiplier and restoring divider.
`default_nettype none
module asrve_datapath (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// configuration write
	input  wire logic                   cfg_we,
	input  wire logic [2:0]             cfg_index,
	input  wire logic [31:0]            cfg_data,
	// input item
	input  wire logic [1:0]             action,
	input  wire logic signed [31:0]     time_left,
	// result payload
	output logic [15:0]                 level,
	output logic                        finished,
	output logic                        retrigger,
	output logic [1:0]                  phase,
	input  wire asrve_pkg::ctrl_cmd_t   cmd,
	output asrve_pkg::dp_status_t       status
);

	// Configuration registers
	logic [15:0]        peak_q;
	logic [31:0]        attack_q;
	logic signed [31:0] sustain_q;
	logic [31:0]        release_q;
	logic [31:0]        loop_delay_q;
	logic               loop_en_q;

	// Envelope state
	asrve_pkg::env_phase_t ph_q;
	logic [31:0]           pe_q;
	logic                  lp_q;
	logic [31:0]           le_q;

	// Snapshot for level computation
	asrve_pkg::env_phase_t snap_ph_q;
	logic [31:0]           snap_e_q;
	logic                  snap_lp_q;
	logic                  trig_q;

	// Prepared operands
	logic                  need_div_q;
	logic [15:0]           const_lvl_q;
	logic                  fin_q;
	logic [31:0]           mul_b_q;
	logic [31:0]           divisor_q;

	// Divider
	logic [31:0]           rem_q;
	logic [15:0]           quo_q;
	logic [3:0]            cnt_q;

	// Result register
	logic [15:0]           level_q;
	logic                  fin_out_q;
	logic                  trig_out_q;
	logic [1:0]            phase_q;

	// Next-state values of the accept cycle
	asrve_pkg::env_phase_t ph_d, snap_ph_d;
	logic [31:0]           pe_d, le_d, pe_i, le_i, snap_e_d;
	logic                  lp_d, trig_d, snap_lp_d;
	logic                  att_done_i, sus_pos, sus_neg;
	logic signed [32:0]    tl_x, neg_sus;

	// Prep-cycle values
	logic                  p_att_done, p_rel_done;
	logic [15:0]           pk_clamped;

	// Divider step values
	logic [32:0]           div_t;
	logic                  div_ge;
	logic [47:0]           product;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q       <= asrve_pkg::PEAK_RESET;
			attack_q     <= '0;
			sustain_q    <= '0;
			release_q    <= '0;
			loop_delay_q <= '0;
			loop_en_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				asrve_pkg::CFG_PEAK_VOLUME:  peak_q       <= cfg_data[15:0];
				asrve_pkg::CFG_ATTACK_TICKS: attack_q     <= cfg_data;
				asrve_pkg::CFG_SUSTAIN:      sustain_q    <= $signed(cfg_data);
				asrve_pkg::CFG_RELEASE:      release_q    <= cfg_data;
				asrve_pkg::CFG_LOOP_DELAY:   loop_delay_q <= cfg_data;
				asrve_pkg::CFG_LOOP_ENABLE:  loop_en_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Action decode and state update
	always_comb begin
		pe_i       = asrve_pkg::sat_inc(pe_q);
		le_i       = lp_q ? asrve_pkg::sat_inc(le_q) : le_q;
		att_done_i = (attack_q == '0) || (pe_i >= attack_q);
		tl_x       = {time_left[31], time_left};
		neg_sus    = 33'sd0 - {sustain_q[31], sustain_q};
		sus_pos    = !sustain_q[31] && (sustain_q != '0) && (pe_i >= sustain_q);
		sus_neg    = sustain_q[31] && (tl_x <= neg_sus);

		ph_d      = ph_q;
		pe_d      = pe_q;
		lp_d      = lp_q;
		le_d      = le_q;
		trig_d    = 1'b0;
		snap_ph_d = ph_q;
		snap_e_d  = pe_q;
		snap_lp_d = lp_q;

		case (action)
			asrve_pkg::ACT_TICK: begin
				pe_d      = pe_i;
				le_d      = le_i;
				snap_e_d  = pe_i;
				case (ph_q)
					asrve_pkg::PH_ATTACK: begin
						if (att_done_i) begin
							ph_d = asrve_pkg::PH_SUSTAIN;
							pe_d = '0;
						end
					end
					asrve_pkg::PH_SUSTAIN: begin
						if (sus_pos || sus_neg) begin
							ph_d = asrve_pkg::PH_RELEASE;
							pe_d = '0;
							if (loop_en_q) begin
								if (loop_delay_q == '0) begin
									trig_d = 1'b1;
								end else begin
									lp_d = 1'b1;
									le_d = '0;
								end
							end
						end
					end
					default: ;
				endcase
			end
			asrve_pkg::ACT_FINAL_REL: begin
				if (ph_q != asrve_pkg::PH_RELEASE) begin
					ph_d = asrve_pkg::PH_RELEASE;
					pe_d = '0;
				end
				if (loop_en_q) begin
					lp_d = 1'b0;
				end
				snap_ph_d = ph_d;
				snap_e_d  = pe_d;
				snap_lp_d = lp_d;
			end
			asrve_pkg::ACT_SAMPLE_END: begin
				if (loop_en_q && lp_q && (le_q >= loop_delay_q)) begin
					trig_d = 1'b1;
					lp_d   = 1'b0;
				end
				snap_lp_d = lp_d;
			end
			default: begin
				ph_d      = asrve_pkg::PH_ATTACK;
				pe_d      = '0;
				lp_d      = 1'b0;
				le_d      = '0;
				snap_ph_d = asrve_pkg::PH_ATTACK;
				snap_e_d  = '0;
				snap_lp_d = 1'b0;
			end
		endcase
	end

	// Envelope state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= asrve_pkg::PH_ATTACK;
			pe_q <= '0;
			lp_q <= 1'b0;
			le_q <= '0;
		end else if (cmd.accept) begin
			ph_q <= ph_d;
			pe_q <= pe_d;
			lp_q <= lp_d;
			le_q <= le_d;
		end
	end

	// Snapshot of the state the level is taken from
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			snap_ph_q <= snap_ph_d;
			snap_e_q  <= snap_e_d;
			snap_lp_q <= snap_lp_d;
			trig_q    <= trig_d;
		end
	end

	// Ramp decisions and multiplier operand
	assign p_att_done = (attack_q == '0) || (snap_e_q >= attack_q);
	assign p_rel_done = (release_q == '0) || (snap_e_q >= release_q);
	assign pk_clamped = asrve_pkg::clamp_level(peak_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			need_div_q <= 1'b0;
		end else if (cmd.prep) begin
			case (snap_ph_q)
				asrve_pkg::PH_ATTACK:  need_div_q <= !p_att_done;
				asrve_pkg::PH_RELEASE: need_div_q <= !p_rel_done;
				default:               need_div_q <= 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			fin_q <= (snap_ph_q == asrve_pkg::PH_RELEASE) && p_rel_done && !snap_lp_q;
			if (snap_ph_q == asrve_pkg::PH_RELEASE) begin
				const_lvl_q <= '0;
				mul_b_q     <= release_q - snap_e_q;
				divisor_q   <= release_q;
			end else begin
				const_lvl_q <= pk_clamped;
				mul_b_q     <= snap_e_q;
				divisor_q   <= attack_q;
			end
		end
	end

	// Multiply, then restoring division one quotient bit a cycle.
	// The ramp numerator is at most peak * divisor, so the quotient fits 16 bits
	// and the upper 32 product bits already sit below the divisor.
	assign product = {32'd0, peak_q} * {16'd0, mul_b_q};
	assign div_t   = {rem_q, quo_q[15]};
	assign div_ge  = div_t >= {1'b0, divisor_q};

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			rem_q <= product[47:16];
			quo_q <= product[15:0];
		end else if (cmd.div_step) begin
			rem_q <= div_ge ? 32'(div_t - {1'b0, divisor_q}) : div_t[31:0];
			quo_q <= {quo_q[14:0], div_ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.mul) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + 4'd1;
		end
	end

	assign status.need_div = need_div_q;
	assign status.div_last = (cnt_q == {asrve_pkg::DIV_STEPS_W{1'b1}});

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			level_q    <= need_div_q ? asrve_pkg::clamp_level(quo_q) : const_lvl_q;
			fin_out_q  <= fin_q;
			trig_out_q <= trig_q;
			phase_q    <= ph_q;
		end
	end

	assign level     = level_q;
	assign finished  = fin_out_q;
	assign retrigger = trig_out_q;
	assign phase     = phase_q;

endmodule
`default_nettype wire

@@ rtl/core/asr_volume_envelope_unit.sv @@
// Top level of the attack-sustain-release volume envelope for one voice.
// Per item: accept in idle, prepare, multiply, then on a ramp a 16-step restoring
// divider that gives one quotient bit a cycle, then load of the output register.
// One item at a time; a full output register that is not read holds the load.
// A new item is taken while the previous result still waits in the output register.
// Reset: phase attack, counters and loop state cleared, registers at defaults.
`default_nettype none
module asr_volume_envelope_unit (
	input  wire logic    clk,
	input  wire logic    arst_n,
	asrve_in_if.sink     in_ch,
	asrve_out_if.source  out_ch,
	asrve_cfg_if.sink    cfg_ch
);

	asrve_pkg::ctrl_cmd_t  cmd;
	asrve_pkg::dp_status_t status;

	// Configuration writes are always taken
	assign cfg_ch.ready = 1'b1;

	// Sequencer
	asrve_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Datapath
	asrve_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_ch.valid),
		.cfg_index (cfg_ch.index),
		.cfg_data  (cfg_ch.data),
		.action    (in_ch.action),
		.time_left (in_ch.time_left),
		.level     (out_ch.level),
		.finished  (out_ch.finished),
		.retrigger (out_ch.retrigger),
		.phase     (out_ch.phase),
		.cmd       (cmd),
		.status    (status)
	);

endmodule
`default_nettype wire

@@ sim/tb_asr_volume_envelope_unit.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the attack-sustain-release volume envelope unit.
module tb_asr_volume_envelope_unit;

	localparam int SETTLE_CYCLES = 32;   // beyond the slowest ramp latency
	localparam int HOLD_CYCLES   = 150;  // long result hold-off for the pressure test

	// One envelope result as the block reports it
	typedef struct packed {
		logic [15:0]           level;
		logic                  finished;
		logic                  retrigger;
		asrve_pkg::env_phase_t phase;
	} env_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	asrve_in_if  in_if ();
	asrve_out_if out_if ();
	asrve_cfg_if cfg_if ();

	asr_volume_envelope_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_if),
		.out_ch (out_if),
		.cfg_ch (cfg_if)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Envelope state and register copies, at their reset values
	asrve_pkg::env_phase_t voice_phase = asrve_pkg::PH_ATTACK;
	logic [31:0] phase_ticks    = '0;
	logic        loop_armed     = 1'b0;
	logic [31:0] loop_ticks     = '0;
	logic [15:0] peak_cfg       = asrve_pkg::PEAK_RESET;
	logic [31:0] attack_cfg     = '0;
	logic signed [31:0] sustain_cfg = '0;
	logic [31:0] release_cfg    = '0;
	logic [31:0] loop_delay_cfg = '0;
	logic        loop_en_cfg    = 1'b0;

	env_result_t envelope_due[$];
	int          mismatch_count = 0;
	bit          src_idle_on    = 1'b1;
	bit          sink_idle_on   = 1'b1;
	bit          hold_request   = 1'b0;
	logic        sink_hold      = 1'b0;

	// Tick counter that sticks at all ones
	function automatic logic [31:0] count_up(input logic [31:0] v);
		return (&v) ? v : v + 32'd1;
	endfunction

	// Level from the present state, floored and clamped to 10.0
	function automatic logic [15:0] envelope_level();
		logic [63:0] q;
		logic [31:0] left;
		q = 64'(peak_cfg);
		if (voice_phase == asrve_pkg::PH_ATTACK && attack_cfg != 0 &&
				phase_ticks < attack_cfg) begin
			q = q * phase_ticks / attack_cfg;
		end else if (voice_phase == asrve_pkg::PH_RELEASE) begin
			if (release_cfg == 0 || phase_ticks >= release_cfg) begin
				q = '0;
			end else begin
				left = release_cfg - phase_ticks;
				q = q * left / release_cfg;
			end
		end
		return (q > 64'(asrve_pkg::LEVEL_MAX)) ? asrve_pkg::LEVEL_MAX : q[15:0];
	endfunction

	function automatic logic envelope_finished();
		return voice_phase == asrve_pkg::PH_RELEASE && !loop_armed &&
			(release_cfg == 0 || phase_ticks >= release_cfg);
	endfunction

	// Move into release; a non-final one may ask for a duplicate voice
	function automatic logic enter_release(input logic final_rel);
		logic trig;
		trig = 1'b0;
		if (voice_phase != asrve_pkg::PH_RELEASE) begin
			voice_phase = asrve_pkg::PH_RELEASE;
			phase_ticks = '0;
			if (loop_en_cfg && !final_rel) begin
				if (loop_delay_cfg == 0) begin
					trig = 1'b1;
				end else begin
					loop_armed = 1'b1;
					loop_ticks = '0;
				end
			end
		end
		if (loop_en_cfg && final_rel)
			loop_armed = 1'b0;
		return trig;
	endfunction

	// Expected result of one accepted item; advances the envelope state
	function automatic env_result_t envelope_step(input logic [1:0] act,
			input logic signed [31:0] tl);
		env_result_t r;
		r.retrigger = 1'b0;
		if (act == asrve_pkg::ACT_TICK) begin
			phase_ticks = count_up(phase_ticks);
			if (loop_armed)
				loop_ticks = count_up(loop_ticks);
			r.level    = envelope_level();
			r.finished = envelope_finished();
			if (voice_phase == asrve_pkg::PH_ATTACK) begin
				if (attack_cfg == 0 || phase_ticks >= attack_cfg) begin
					voice_phase = asrve_pkg::PH_SUSTAIN;
					phase_ticks = '0;
				end
			end else if (voice_phase == asrve_pkg::PH_SUSTAIN) begin
				if ((sustain_cfg > 0 && longint'(phase_ticks) >= longint'(sustain_cfg)) ||
						(sustain_cfg < 0 && longint'(tl) <= -longint'(sustain_cfg)))
					r.retrigger = enter_release(1'b0);
			end
		end else begin
			case (act)
				asrve_pkg::ACT_FINAL_REL: begin
					void'(enter_release(1'b1));
				end
				asrve_pkg::ACT_SAMPLE_END: begin
					if (loop_en_cfg && loop_armed && loop_ticks >= loop_delay_cfg) begin
						r.retrigger = 1'b1;
						loop_armed  = 1'b0;
					end
				end
				default: begin
					voice_phase = asrve_pkg::PH_ATTACK;
					phase_ticks = '0;
					loop_armed  = 1'b0;
					loop_ticks  = '0;
				end
			endcase
			r.level    = envelope_level();
			r.finished = envelope_finished();
		end
		r.phase = voice_phase;
		return r;
	endfunction

	// Offer one item, with an occasional gap first; valid stays high afterwards
	task automatic send_item(input logic [1:0] act, input logic signed [31:0] tl);
		int gap;
		if (src_idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			in_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_if.valid     <= 1'b1;
		in_if.action    <= act;
		in_if.time_left <= tl;
		do @(posedge clk); while (!in_if.ready);
		envelope_due.push_back(envelope_step(act, tl));
	endtask

	// Register write; the caller lowers valid after the last one
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= val;
		do @(posedge clk); while (!cfg_if.ready);
		case (idx)
			asrve_pkg::CFG_PEAK_VOLUME:  peak_cfg       = val[15:0];
			asrve_pkg::CFG_ATTACK_TICKS: attack_cfg     = val;
			asrve_pkg::CFG_SUSTAIN:      sustain_cfg    = val;
			asrve_pkg::CFG_RELEASE:      release_cfg    = val;
			asrve_pkg::CFG_LOOP_DELAY:   loop_delay_cfg = val;
			asrve_pkg::CFG_LOOP_ENABLE:  loop_en_cfg    = val[0];
			default: ;
		endcase
	endtask

	// Full register set; unused upper data bits carry noise
	task automatic apply_setting(input logic [15:0] peak, input logic [31:0] atk,
			input logic signed [31:0] sus, input logic [31:0] rel,
			input logic [31:0] dly, input logic en);
		write_reg(asrve_pkg::CFG_PEAK_VOLUME, {16'($urandom), peak});
		write_reg(asrve_pkg::CFG_ATTACK_TICKS, atk);
		write_reg(asrve_pkg::CFG_SUSTAIN, sus);
		write_reg(asrve_pkg::CFG_RELEASE, rel);
		write_reg(asrve_pkg::CFG_LOOP_DELAY, dly);
		write_reg(asrve_pkg::CFG_LOOP_ENABLE, {31'($urandom), en});
		cfg_if.valid <= 1'b0;
	endtask

	// Mostly short ramps, now and then the register extremes
	task automatic apply_random_setting();
		logic [15:0] peak;
		logic [31:0] atk, rel, dly;
		logic signed [31:0] sus;
		case ($urandom_range(0, 7))
			0:       peak = '0;
			1:       peak = 16'hFFFF;
			2:       peak = asrve_pkg::LEVEL_MAX;
			default: peak = 16'($urandom);
		endcase
		atk = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : $urandom_range(0, 12);
		case ($urandom_range(0, 9))
			0:       sus = '0;
			1:       sus = 32'sh7FFF_FFFF;
			2:       sus = 32'sh8000_0000;
			3, 4, 5: sus = $urandom_range(1, 10);
			default: sus = -$urandom_range(1, 50);
		endcase
		rel = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : $urandom_range(0, 12);
		dly = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : $urandom_range(0, 15);
		apply_setting(peak, atk, sus, rel, dly, $urandom_range(0, 2) != 0);
	endtask

	function automatic logic signed [31:0] random_time_left();
		case ($urandom_range(0, 7))
			0:       return -32'sd1;
			1:       return {1'b0, 31'($urandom)};
			default: return $urandom_range(0, 80);
		endcase
	endfunction

	// Stop offering, wait for every result, then let the block settle
	task automatic drain_results();
		in_if.valid <= 1'b0;
		while (envelope_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// A voice playing a sample: ticks count the sample down, sample end at zero,
	// with some releases, restarts and stray items mixed in
	task automatic run_lifecycle(input int n_items);
		int countdown;
		int r;
		int k;
		countdown = $urandom_range(0, 60);
		send_item(asrve_pkg::ACT_RESTART, random_time_left());
		for (k = 1; k < n_items; k++) begin
			r = $urandom_range(0, 99);
			if (r < 3) begin
				send_item(asrve_pkg::ACT_RESTART, random_time_left());
				countdown = $urandom_range(0, 60);
			end else if (r < 8) begin
				send_item(asrve_pkg::ACT_FINAL_REL, random_time_left());
			end else if (r < 12) begin
				send_item(asrve_pkg::ACT_SAMPLE_END, random_time_left());
			end else if (r < 16) begin
				send_item(asrve_pkg::ACT_TICK, random_time_left());
			end else if (countdown == 0) begin
				send_item(asrve_pkg::ACT_SAMPLE_END, 32'sd0);
				countdown = $urandom_range(0, 60);
			end else begin
				countdown--;
				send_item(asrve_pkg::ACT_TICK, countdown);
			end
		end
	endtask

	// Reset registers: instant attack, endless sustain, instant release
	task automatic test_reset_defaults();
		send_item(asrve_pkg::ACT_TICK, -32'sd1);
		send_item(asrve_pkg::ACT_TICK, 32'sh7FFF_FFFF);
		send_item(asrve_pkg::ACT_SAMPLE_END, 32'sd0);
		send_item(asrve_pkg::ACT_FINAL_REL, 32'sd5);
		send_item(asrve_pkg::ACT_TICK, 32'sd0);
		send_item(asrve_pkg::ACT_RESTART, -32'sd1);
	endtask

	// Full-scale ramps with clamping, timed sustain, immediate retrigger
	task automatic test_ramps_and_loop();
		int k;
		drain_results();
		apply_setting(16'hFFFF, 32'd3, 32'sd2, 32'd3, 32'd0, 1'b1);
		send_item(asrve_pkg::ACT_RESTART, 32'sd100);
		for (k = 0; k < 9; k++)
			send_item(asrve_pkg::ACT_TICK, 32'sd100);
	endtask

	// Sample-time sustain, delayed retrigger at a sample end
	task automatic test_loop_delay();
		drain_results();
		apply_setting(16'd4096, 32'd0, -32'sd5, 32'd2, 32'd2, 1'b1);
		send_item(asrve_pkg::ACT_RESTART, 32'sd10);
		send_item(asrve_pkg::ACT_TICK, 32'sd10);
		send_item(asrve_pkg::ACT_TICK, 32'sd5);
		send_item(asrve_pkg::ACT_SAMPLE_END, 32'sd0);
		send_item(asrve_pkg::ACT_TICK, 32'sd4);
		send_item(asrve_pkg::ACT_TICK, 32'sd3);
		send_item(asrve_pkg::ACT_SAMPLE_END, 32'sd0);
	endtask

	// Largest release and loop delay, most negative sustain, final release dropping the loop
	task automatic test_register_extremes();
		drain_results();
		apply_setting(16'hFFFF, 32'd0, 32'sh8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		send_item(asrve_pkg::ACT_RESTART, 32'sh7FFF_FFFF);
		send_item(asrve_pkg::ACT_TICK, 32'sh7FFF_FFFF);
		send_item(asrve_pkg::ACT_TICK, 32'sh7FFF_FFFF);
		send_item(asrve_pkg::ACT_TICK, 32'sd0);
		send_item(asrve_pkg::ACT_SAMPLE_END, -32'sd1);
		send_item(asrve_pkg::ACT_FINAL_REL, 32'sd0);
	endtask

	task automatic test_random_lifecycles();
		int p;
		for (p = 0; p < 30; p++) begin
			drain_results();
			apply_random_setting();
			src_idle_on  = ($urandom_range(0, 3) != 0);
			sink_idle_on = ($urandom_range(0, 3) != 0);
			run_lifecycle(45);
		end
	endtask

	// Results held off for a long stretch while items keep coming
	task automatic test_backpressure();
		drain_results();
		apply_setting(16'd20000, 32'd6, 32'sd4, 32'd6, 32'd3, 1'b1);
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b1;
		hold_request = 1'b1;
		run_lifecycle(60);
	endtask

	// Back-to-back transfers on both sides
	task automatic test_steady_stream();
		drain_results();
		apply_random_setting();
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		run_lifecycle(150);
	endtask

	// Result side: check each transfer, then choose ready for the next cycle
	initial begin : result_sink
		int stall_left;
		env_result_t due;
		stall_left = 0;
		out_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_if.valid && out_if.ready) begin
				if (envelope_due.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: result transfer with no prediction pending", $time);
				end else begin
					due = envelope_due.pop_front();
					if (out_if.level !== due.level || out_if.finished !== due.finished ||
							out_if.retrigger !== due.retrigger || out_if.phase !== due.phase) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display({"%0t: expected level %0d finished %0b retrigger %0b ",
								"phase %0d, got %0d %0b %0b %0d"}, $time,
								due.level, due.finished, due.retrigger, due.phase,
								out_if.level, out_if.finished, out_if.retrigger, out_if.phase);
					end
				end
			end
			if (sink_hold) begin
				out_if.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_if.ready <= 1'b0;
			end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
				stall_left = $urandom_range(1, 5) - 1;
				out_if.ready <= 1'b0;
			end else begin
				out_if.ready <= 1'b1;
			end
		end
	end

	// Long hold-off of the result side, counted here
	initial begin : sink_holdoff
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				sink_hold <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				sink_hold <= 1'b0;
			end
		end
	end

	// Test sequence
	initial begin
		in_if.valid     <= 1'b0;
		in_if.action    <= asrve_pkg::ACT_TICK;
		in_if.time_left <= '0;
		cfg_if.valid    <= 1'b0;
		cfg_if.index    <= asrve_pkg::CFG_PEAK_VOLUME;
		cfg_if.data     <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_ramps_and_loop();
		test_loop_delay();
		test_register_extremes();
		test_random_lifecycles();
		test_backpressure();
		test_steady_stream();
		drain_results();

		if (mismatch_count == 0 && envelope_due.size() == 0)
			$display("tb_asr_volume_envelope_unit OK");
		else
			$display("tb_asr_volume_envelope_unit NOT OK");
		$finish;
	end

	// Watchdog
	initial begin
		#4_000_000;
		$display("tb_asr_volume_envelope_unit NOT OK");
		$finish;
	end

endmodule
